// File: src/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants for the 3x3 matrix inverse pipeline
// Payload structs, cofactor index tables and the divider stage record.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int unsigned NumEntries = 9;
  localparam int unsigned DivSteps   = 33;

  typedef logic signed [31:0] word_t;
  typedef logic [3:0]         idx_t;

  typedef struct packed {
    word_t e00; word_t e01; word_t e02;
    word_t e10; word_t e11; word_t e12;
    word_t e20; word_t e21; word_t e22;
  } in_t;

  typedef struct packed {
    word_t r00; word_t r01; word_t r02;
    word_t r10; word_t r11; word_t r12;
    word_t r20; word_t r21; word_t r22;
    logic  singular;
  } out_t;

  // Cofactor k is m[CA[k]] * m[CB[k]] - m[CC[k]] * m[CD[k]].
  localparam idx_t CA [NumEntries] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam idx_t CB [NumEntries] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam idx_t CC [NumEntries] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam idx_t CD [NumEntries] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

  typedef struct packed {
    logic [95:0] rem;
    logic [32:0] quo;
    logic        neg;
    logic        ovf;
  } div_lane_t;

  typedef struct packed {
    logic                            valid;
    logic                            singular;
    logic [128:0]                    dsh;
    div_lane_t [NumEntries-1:0]      lane;
    in_t                             mat;
  } div_stage_t;

  function automatic word_t get_entry(input in_t m, input idx_t k);
    word_t v;
    case (k)
      4'd0: v = m.e00;
      4'd1: v = m.e01;
      4'd2: v = m.e02;
      4'd3: v = m.e10;
      4'd4: v = m.e11;
      4'd5: v = m.e12;
      4'd6: v = m.e20;
      4'd7: v = m.e21;
      default: v = m.e22;
    endcase
    return v;
  endfunction

endpackage

// File: src/mi3_front.sv
// ----------------------------------------------------------------------------
// mi3_front: cofactors, determinant and divider setup
// Seven register stages from the input matrix to the first divider step.
// ----------------------------------------------------------------------------
module mi3_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  mi3_pkg::in_t       in_mat,
  output mi3_pkg::div_stage_t out_stage
);
  import mi3_pkg::*;

  logic [5:0] valid;
  in_t        mat [6];

  logic signed [63:0] pa [NumEntries];
  logic signed [63:0] pb [NumEntries];
  logic signed [63:0] cof [NumEntries];
  logic [63:0]        cm3 [NumEntries];
  logic               cn3 [NumEntries];
  logic [63:0]        pl [3];
  logic [63:0]        ph [3];
  logic               psg [3];
  logic [63:0]        cm4 [NumEntries];
  logic               cn4 [NumEntries];
  logic signed [97:0] term [3];
  logic [63:0]        cm5 [NumEntries];
  logic               cn5 [NumEntries];
  logic signed [97:0] det;
  logic [63:0]        cm6 [NumEntries];
  logic               cn6 [NumEntries];
  logic [96:0]        dmag;
  logic               dneg;
  logic               sing;
  div_stage_t         st7;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    mat[0] <= in_mat;
    for (int i = 1; i < 6; i++) begin
      mat[i] <= mat[i-1];
    end
  end

  // Stage 1: the eighteen 32x32 products.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NumEntries; k++) begin
      pa[k] <= get_entry(in_mat, CA[k]) * get_entry(in_mat, CB[k]);
      pb[k] <= get_entry(in_mat, CC[k]) * get_entry(in_mat, CD[k]);
    end
  end

  // Stage 2: cofactors; the difference always fits in 64 bits.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NumEntries; k++) begin
      cof[k] <= pa[k] - pb[k];
    end
  end

  // Stage 3: partial products of the first-row expansion, cofactor magnitudes.
  always_ff @(posedge clk) begin
    logic [31:0] ma;
    logic [63:0] mc;
    word_t       a;
    for (int j = 0; j < 3; j++) begin
      a      = get_entry(mat[1], idx_t'(j));
      ma     = a[31] ? 32'(-a) : 32'(a);
      mc     = cof[3*j][63] ? 64'(-cof[3*j]) : 64'(cof[3*j]);
      pl[j]  <= 64'(ma) * 64'(mc[31:0]);
      ph[j]  <= 64'(ma) * 64'(mc[63:32]);
      psg[j] <= a[31] ^ cof[3*j][63];
    end
    for (int k = 0; k < NumEntries; k++) begin
      cm3[k] <= cof[k][63] ? 64'(-cof[k]) : 64'(cof[k]);
      cn3[k] <= cof[k][63];
    end
  end

  // Stage 4: signed 98-bit terms.
  always_ff @(posedge clk) begin
    logic [97:0] t;
    for (int j = 0; j < 3; j++) begin
      t       = {34'd0, pl[j]} + {2'd0, ph[j], 32'd0};
      term[j] <= psg[j] ? $signed(-t) : $signed(t);
    end
    cm4 <= cm3;
    cn4 <= cn3;
  end

  // Stage 5: determinant.
  always_ff @(posedge clk) begin
    det <= term[0] + term[1] + term[2];
    cm5 <= cm4;
    cn5 <= cn4;
  end

  // Stage 6: determinant magnitude and sign.
  always_ff @(posedge clk) begin
    dneg <= det[97];
    dmag <= det[97] ? 97'(-det) : 97'(det);
    sing <= (det == '0);
    cm6  <= cm5;
    cn6  <= cn5;
  end

  // Stage 7: a quotient of 2^33 or more saturates, so only 33 bits are divided.
  always_comb begin
    st7.valid    = valid[5] & ~rst;
    st7.singular = sing;
    st7.dsh      = {dmag, 32'd0};
    st7.mat      = mat[5];
    for (int k = 0; k < NumEntries; k++) begin
      st7.lane[k].rem = {cm6[k], 32'd0};
      st7.lane[k].quo = '0;
      st7.lane[k].neg = cn6[k] ^ dneg;
      st7.lane[k].ovf = ({35'd0, cm6[k]} >= {1'b0, dmag, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    out_stage <= st7;
  end

endmodule

// File: src/mi3_div_step.sv
// ----------------------------------------------------------------------------
// mi3_div_step: one restoring division step for all nine entries
// Produces one quotient bit per entry and halves the shifted divisor.
// ----------------------------------------------------------------------------
module mi3_div_step (
  input  logic                clk,
  input  logic                rst,
  input  mi3_pkg::div_stage_t in_stage,
  output mi3_pkg::div_stage_t out_stage
);
  import mi3_pkg::*;

  div_stage_t nxt;

  always_comb begin
    logic [128:0] wide_rem;
    logic         ge;
    nxt       = in_stage;
    nxt.valid = in_stage.valid & ~rst;
    nxt.dsh   = in_stage.dsh >> 1;
    for (int k = 0; k < NumEntries; k++) begin
      wide_rem        = {33'd0, in_stage.lane[k].rem};
      ge              = (wide_rem >= in_stage.dsh);
      nxt.lane[k].rem = ge ? 96'(wide_rem - in_stage.dsh) : in_stage.lane[k].rem;
      nxt.lane[k].quo = {in_stage.lane[k].quo[31:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    out_stage <= nxt;
  end

endmodule

// File: src/matrix3x3_inverse_unit.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse_unit: pipelined inverse of a 3x3 Q16.16 matrix
// Adjugate over determinant, truncated toward zero and saturated.
// ----------------------------------------------------------------------------
// Usage:
// A matrix is transferred in at each rising edge where start is high and
// busy is low. busy is always low, so one matrix can enter every cycle.
// Each result is shown on result for exactly one cycle with done high;
// the receiver must take it then, it cannot hold results off.
// From the input transfer to the result transfer, the pipeline runs thus:
// seven stages form the cofactors, the determinant and its magnitude,
// 33 stages each produce one quotient bit of a restoring divider, and
// one stage saturates and registers the result. Throughput is one
// matrix per cycle.
// A zero determinant returns the input matrix with singular set.
// Reset clears all valid bits; items in flight are dropped.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  mi3_pkg::in_t  matrix,
  output logic          done,
  output mi3_pkg::out_t result
);
  import mi3_pkg::*;

  div_stage_t pipe [DivSteps+1];
  div_stage_t last;
  word_t      res [NumEntries];

  assign busy = 1'b0;

  mi3_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start & ~busy),
    .in_mat    (matrix),
    .out_stage (pipe[0])
  );

  for (genvar s = 0; s < DivSteps; s++) begin : g_div
    mi3_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_stage  (pipe[s]),
      .out_stage (pipe[s+1])
    );
  end

  assign last = pipe[DivSteps];

  always_comb begin
    logic [32:0] q;
    for (int k = 0; k < NumEntries; k++) begin
      q = last.lane[k].quo;
      if (!last.lane[k].neg) begin
        res[k] = (last.lane[k].ovf || q[32] || q[31]) ? 32'sh7FFFFFFF : $signed(q[31:0]);
      end else begin
        res[k] = (last.lane[k].ovf || q > 33'h080000000) ? 32'sh80000000
                                                          : $signed(-q[31:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (last.singular) begin
      result <= {last.mat, 1'b1};
    end else begin
      result <= {res[0], res[1], res[2], res[3], res[4], res[5], res[6], res[7], res[8],
                 1'b0};
    end
  end

`ifndef SYNTHESIS
  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk) disable iff (rst) done |-> $past(start, 41))
    else $error("result without matching input");
  a_singular_pass: assert property (@(posedge clk) disable iff (rst)
    (done && result.singular) |-> (result.r00 == $past(matrix.e00, 41)
                                   && result.r22 == $past(matrix.e22, 41)))
    else $error("singular result does not echo input");
`endif

endmodule
